[src/assert_macros.svh]
// assertion macros shared by the rasterizer rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/emr_pkg.sv]
// types, microcode program and constants of the ellipse rasterizer
// no dependencies
package emr_pkg;

  localparam int COORD_BITS_DEF  = 10;
  localparam int RADIUS_BITS_DEF = 9;
  localparam int PC_BITS         = 5;

  typedef logic [PC_BITS-1:0] upc_t;

  localparam upc_t A_IDLE   = 5'd0;
  localparam upc_t A_START  = 5'd1;
  localparam upc_t A_SETTLE = 5'd5;
  localparam upc_t A_SEED   = 5'd6;
  localparam upc_t A_ADV1   = 5'd15;
  localparam upc_t A_ADV2   = 5'd17;
  localparam upc_t A_DONE   = 5'd19;
  localparam upc_t A_EMIT   = 5'd20;
  localparam upc_t A_MARK   = 5'd24;

  typedef enum logic [1:0] {
    PH_R1   = 2'd0,
    PH_R2   = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_SQ_RX,
    OP_SQ_RY,
    OP_MUL_RX2_RY,
    OP_INIT_D,
    OP_SQ_XP,
    OP_MUL_RY2_T,
    OP_D_2T_SQ_Y,
    OP_MUL_RX2_T,
    OP_D_ADD_T_SQ_YM,
    OP_D_ADD_T,
    OP_MUL_RX2_RY2,
    OP_D_SUB_2T,
    OP_ADV1_A,
    OP_ADV1_B,
    OP_ADV2_A,
    OP_ADV2_B,
    OP_SET_DONE,
    OP_EMIT_PP,
    OP_EMIT_PM,
    OP_EMIT_MM,
    OP_EMIT_MP,
    OP_MARK
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_SETTLE,
    C_OUT,
    C_OUT_JUMP
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic   accept;
    logic   func;
    phase_t phase;
    logic   need_seed;
    logic   y_zero;
    logic   out_free;
  } stat_t;

  typedef struct packed {
    op_t  op;
    logic ready;
  } ctrl_t;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_JUMP, target: A_IDLE};
    case (pc)
      5'd0:  w = '{op: OP_NOP,           cond: C_DISPATCH, target: A_IDLE};
      5'd1:  w = '{op: OP_SQ_RX,         cond: C_NEXT,     target: A_IDLE};
      5'd2:  w = '{op: OP_SQ_RY,         cond: C_NEXT,     target: A_IDLE};
      5'd3:  w = '{op: OP_MUL_RX2_RY,    cond: C_NEXT,     target: A_IDLE};
      5'd4:  w = '{op: OP_INIT_D,        cond: C_NEXT,     target: A_IDLE};
      5'd5:  w = '{op: OP_NOP,           cond: C_SETTLE,   target: A_IDLE};
      5'd6:  w = '{op: OP_SQ_XP,         cond: C_NEXT,     target: A_IDLE};
      5'd7:  w = '{op: OP_MUL_RY2_T,     cond: C_NEXT,     target: A_IDLE};
      5'd8:  w = '{op: OP_D_2T_SQ_Y,     cond: C_NEXT,     target: A_IDLE};
      5'd9:  w = '{op: OP_MUL_RX2_T,     cond: C_NEXT,     target: A_IDLE};
      5'd10: w = '{op: OP_D_ADD_T_SQ_YM, cond: C_NEXT,     target: A_IDLE};
      5'd11: w = '{op: OP_MUL_RX2_T,     cond: C_NEXT,     target: A_IDLE};
      5'd12: w = '{op: OP_D_ADD_T,       cond: C_NEXT,     target: A_IDLE};
      5'd13: w = '{op: OP_MUL_RX2_RY2,   cond: C_NEXT,     target: A_IDLE};
      5'd14: w = '{op: OP_D_SUB_2T,      cond: C_JUMP,     target: A_SETTLE};
      5'd15: w = '{op: OP_ADV1_A,        cond: C_NEXT,     target: A_IDLE};
      5'd16: w = '{op: OP_ADV1_B,        cond: C_JUMP,     target: A_SETTLE};
      5'd17: w = '{op: OP_ADV2_A,        cond: C_NEXT,     target: A_IDLE};
      5'd18: w = '{op: OP_ADV2_B,        cond: C_JUMP,     target: A_SETTLE};
      5'd19: w = '{op: OP_SET_DONE,      cond: C_NEXT,     target: A_IDLE};
      5'd20: w = '{op: OP_EMIT_PP,       cond: C_OUT,      target: A_IDLE};
      5'd21: w = '{op: OP_EMIT_PM,       cond: C_OUT,      target: A_IDLE};
      5'd22: w = '{op: OP_EMIT_MM,       cond: C_OUT,      target: A_IDLE};
      5'd23: w = '{op: OP_EMIT_MP,       cond: C_OUT_JUMP, target: A_IDLE};
      5'd24: w = '{op: OP_MARK,          cond: C_OUT_JUMP, target: A_IDLE};
      default: w = '{op: OP_NOP,         cond: C_JUMP,     target: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

[src/ellipse_midpoint_rasterizer.sv]
// top level of the midpoint ellipse rasterizer: datapath with one shared multiplier
// depends on emr_pkg, emr_seq and assert_macros.svh
// an advance item steps its region, seeds region two when needed or ends the walk at y zero,
// then emits four points; a start item squares the radii and seeds region one first; a
// finished advance gives its marker; a new item is taken only in idle, after the last one's
// microcode steps and output beats, which back-pressure holds; sync rst: idle, output empty, ellipse finished
`include "assert_macros.svh"

module ellipse_midpoint_rasterizer #(
  parameter int COORD_BITS  = emr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = emr_pkg::RADIUS_BITS_DEF,
  localparam int PW   = COORD_BITS + 2,
  localparam int SDW  = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8,
  localparam int MDW  = ((2 * PW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [SDW-1:0] s_tdata,   // center_x, center_y, radius_x, radius_y, zero fill
  input  logic           s_tuser,   // func
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [MDW-1:0] m_tdata,   // pixel_x, pixel_y, zero fill
  output logic [1:0]     m_tuser,   // point_valid, finished
  output logic           m_tlast    // last_of_item
);

  localparam int RB = RADIUS_BITS;
  localparam int CB = COORD_BITS;
  localparam int DW = 4 * RB + 6;
  localparam int XW = RB + 1;
  localparam int MA = 2 * RB;
  localparam int MB = 2 * RB + 2;
  localparam int MP = 4 * RB + 2;
  localparam int EW = ((CB > XW) ? CB : XW) + 2;

  emr_pkg::stat_t  stat;
  emr_pkg::ctrl_t  ctrl;
  emr_pkg::phase_t phase;

  logic [CB-1:0]        cx;
  logic [CB-1:0]        cy;
  logic [RB-1:0]        rad_x;
  logic [RB-1:0]        rad_y;
  logic [2*RB-1:0]      rx2;
  logic [2*RB-1:0]      ry2;
  logic [XW-1:0]        x;
  logic [RB-1:0]        y;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] d;
  logic signed [DW-1:0] t;
  logic                 dflag;

  logic                 accept;
  logic                 out_free;
  logic [MA-1:0]        mul_a;
  logic [MB-1:0]        mul_b;
  logic [MP-1:0]        prod;
  logic signed [DW-1:0] prod_w;
  logic signed [DW-1:0] rx2_w;
  logic signed [DW-1:0] ry2_w;
  logic [XW:0]          xp;
  logic [RB-1:0]        ym;
  logic signed [EW-1:0] ex_p;
  logic signed [EW-1:0] ex_m;
  logic signed [EW-1:0] ey_p;
  logic signed [EW-1:0] ey_m;
  logic                 fin;

  logic [PW-1:0]        o_px;
  logic [PW-1:0]        o_py;
  logic                 o_pv;
  logic                 o_last;
  logic                 o_fin;
  logic                 m_tvalid_next;
  logic [PW-1:0]        o_px_next;
  logic [PW-1:0]        o_py_next;
  logic                 o_pv_next;
  logic                 o_last_next;
  logic                 o_fin_next;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = ctrl.ready;

  assign stat.accept    = accept;
  assign stat.func      = s_tuser;
  assign stat.phase     = phase;
  assign stat.need_seed = (phase == emr_pkg::PH_R1) && !(dx < dy);
  assign stat.y_zero    = (phase == emr_pkg::PH_R2) && (y == '0);
  assign stat.out_free  = out_free;

  emr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign rx2_w  = signed'(DW'(rx2));
  assign ry2_w  = signed'(DW'(ry2));
  assign xp     = (XW + 1)'(x) + 1'b1;
  // (y-1)^2 with y at zero squares to one
  assign ym     = (y == '0) ? RB'(1) : y - 1'b1;
  assign prod   = MP'(mul_a) * MP'(mul_b);
  assign prod_w = signed'(DW'(prod));

  assign ex_p = signed'(EW'(cx)) + signed'(EW'(x));
  assign ex_m = signed'(EW'(cx)) - signed'(EW'(x));
  assign ey_p = signed'(EW'(cy)) + signed'(EW'(y));
  assign ey_m = signed'(EW'(cy)) - signed'(EW'(y));
  assign fin  = (phase == emr_pkg::PH_DONE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      emr_pkg::OP_SQ_RX: begin
        mul_a = MA'(rad_x);
        mul_b = MB'(rad_x);
      end
      emr_pkg::OP_SQ_RY: begin
        mul_a = MA'(rad_y);
        mul_b = MB'(rad_y);
      end
      emr_pkg::OP_MUL_RX2_RY: begin
        mul_a = rx2;
        mul_b = MB'(rad_y);
      end
      emr_pkg::OP_SQ_XP: begin
        mul_a = MA'(xp);
        mul_b = MB'(xp);
      end
      emr_pkg::OP_MUL_RY2_T: begin
        mul_a = ry2;
        mul_b = t[MB-1:0];
      end
      emr_pkg::OP_D_2T_SQ_Y: begin
        mul_a = MA'(y);
        mul_b = MB'(y);
      end
      emr_pkg::OP_MUL_RX2_T: begin
        mul_a = rx2;
        mul_b = t[MB-1:0];
      end
      emr_pkg::OP_D_ADD_T_SQ_YM: begin
        mul_a = MA'(ym);
        mul_b = MB'(ym);
      end
      emr_pkg::OP_MUL_RX2_RY2: begin
        mul_a = rx2;
        mul_b = MB'(ry2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= emr_pkg::PH_DONE;
    end else begin
      if (ctrl.op == emr_pkg::OP_INIT_D) begin
        phase <= emr_pkg::PH_R1;
      end else if (ctrl.op == emr_pkg::OP_D_SUB_2T) begin
        phase <= emr_pkg::PH_R2;
      end else if (ctrl.op == emr_pkg::OP_SET_DONE) begin
        phase <= emr_pkg::PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx  <= '0;
      cy  <= '0;
      rx2 <= '0;
      ry2 <= '0;
      x   <= '0;
      y   <= '0;
      dx  <= '0;
      dy  <= '0;
      d   <= '0;
    end else begin
      if (accept && !s_tuser) begin
        cx    <= s_tdata[CB-1:0];
        cy    <= s_tdata[2*CB-1:CB];
        rad_x <= s_tdata[2*CB+RB-1:2*CB];
        rad_y <= s_tdata[2*CB+2*RB-1:2*CB+RB];
        x     <= '0;
        y     <= s_tdata[2*CB+2*RB-1:2*CB+RB];
        dx    <= '0;
      end
      case (ctrl.op)
        emr_pkg::OP_SQ_RX:      rx2 <= prod[2*RB-1:0];
        emr_pkg::OP_SQ_RY:      ry2 <= prod[2*RB-1:0];
        emr_pkg::OP_MUL_RX2_RY: t <= prod_w;
        emr_pkg::OP_INIT_D: begin
          dy <= t <<< 1;
          d  <= (ry2_w <<< 1) + rx2_w - (t <<< 1);
        end
        emr_pkg::OP_SQ_XP:      t <= prod_w;
        emr_pkg::OP_MUL_RY2_T:  t <= prod_w;
        emr_pkg::OP_D_2T_SQ_Y: begin
          d <= t <<< 1;
          t <= prod_w;
        end
        emr_pkg::OP_MUL_RX2_T:  t <= prod_w;
        emr_pkg::OP_D_ADD_T_SQ_YM: begin
          d <= d + t;
          t <= prod_w;
        end
        emr_pkg::OP_D_ADD_T:    d <= d + t;
        emr_pkg::OP_MUL_RX2_RY2: t <= prod_w;
        emr_pkg::OP_D_SUB_2T:   d <= d - (t <<< 1);
        emr_pkg::OP_ADV1_A: begin
          x     <= x + 1'b1;
          dx    <= dx + (ry2_w <<< 1);
          dflag <= d < 0;
          if (!(d < 0)) begin
            y  <= y - 1'b1;
            dy <= dy - (rx2_w <<< 1);
          end
        end
        emr_pkg::OP_ADV1_B: begin
          if (dflag) begin
            d <= d + (dx <<< 1) + (ry2_w <<< 1);
          end else begin
            d <= d + ((dx - dy) <<< 1) + (ry2_w <<< 1);
          end
        end
        emr_pkg::OP_ADV2_A: begin
          y     <= y - 1'b1;
          dy    <= dy - (rx2_w <<< 1);
          dflag <= d > 0;
          if (!(d > 0)) begin
            x  <= x + 1'b1;
            dx <= dx + (ry2_w <<< 1);
          end
        end
        emr_pkg::OP_ADV2_B: begin
          if (dflag) begin
            d <= d + (rx2_w <<< 1) - (dy <<< 1);
          end else begin
            d <= d + (rx2_w <<< 1) + ((dx - dy) <<< 1);
          end
        end
        default: ;
      endcase
    end
  end

  // output item select
  always_comb begin
    m_tvalid_next = 1'b1;
    o_px_next     = ex_p[PW-1:0];
    o_py_next     = ey_p[PW-1:0];
    o_pv_next     = 1'b1;
    o_last_next   = 1'b0;
    o_fin_next    = fin;
    case (ctrl.op)
      emr_pkg::OP_EMIT_PP: begin
        o_px_next = ex_p[PW-1:0];
        o_py_next = ey_p[PW-1:0];
      end
      emr_pkg::OP_EMIT_PM: begin
        o_py_next = ey_m[PW-1:0];
      end
      emr_pkg::OP_EMIT_MM: begin
        o_px_next = ex_m[PW-1:0];
        o_py_next = ey_m[PW-1:0];
      end
      emr_pkg::OP_EMIT_MP: begin
        o_px_next   = ex_m[PW-1:0];
        o_last_next = 1'b1;
      end
      emr_pkg::OP_MARK: begin
        o_px_next   = '0;
        o_py_next   = '0;
        o_pv_next   = 1'b0;
        o_last_next = 1'b1;
        o_fin_next  = 1'b1;
      end
      default: m_tvalid_next = 1'b0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= m_tvalid_next;
      o_px     <= o_px_next;
      o_py     <= o_py_next;
      o_pv     <= o_pv_next;
      o_last   <= o_last_next;
      o_fin    <= o_fin_next;
    end
  end

  assign m_tdata = MDW'({o_py, o_px});
  assign m_tuser = {o_fin, o_pv};
  assign m_tlast = o_last;

  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, !s_tready)
  `ASSERT_IMP(a_marker_form, clk, rst, m_tvalid && !m_tuser[0], m_tlast && m_tuser[1])
  `ASSERT_IMP(a_r1_settled, clk, rst, s_tready && phase == emr_pkg::PH_R1, dx < dy)
  `ASSERT_IMP(a_r2_settled, clk, rst, s_tready && phase == emr_pkg::PH_R2, y != '0)

endmodule

[src/emr_seq.sv]
// microcode sequencer of the ellipse rasterizer: step counter, program rom, jumps
// depends on emr_pkg and assert_macros.svh
`include "assert_macros.svh"

module emr_seq (
  input  logic           clk,
  input  logic           rst,
  input  emr_pkg::stat_t stat,
  output emr_pkg::ctrl_t ctrl
);

  emr_pkg::upc_t   pc;
  emr_pkg::upc_t   pc_next;
  emr_pkg::uword_t uw;
  logic            out_step;

  assign uw         = emr_pkg::ucode(pc);
  assign ctrl.op    = uw.op;
  assign ctrl.ready = (pc == emr_pkg::A_IDLE);
  assign out_step   = (uw.cond == emr_pkg::C_OUT) || (uw.cond == emr_pkg::C_OUT_JUMP);

  always_comb begin
    pc_next = pc;
    case (uw.cond)
      emr_pkg::C_NEXT: pc_next = pc + 1'b1;
      emr_pkg::C_JUMP: pc_next = uw.target;
      emr_pkg::C_DISPATCH: begin
        if (stat.accept) begin
          if (!stat.func) begin
            pc_next = emr_pkg::A_START;
          end else if (stat.phase == emr_pkg::PH_R1) begin
            pc_next = emr_pkg::A_ADV1;
          end else if (stat.phase == emr_pkg::PH_R2) begin
            pc_next = emr_pkg::A_ADV2;
          end else begin
            pc_next = emr_pkg::A_MARK;
          end
        end
      end
      emr_pkg::C_SETTLE: begin
        if (stat.need_seed) begin
          pc_next = emr_pkg::A_SEED;
        end else if (stat.y_zero) begin
          pc_next = emr_pkg::A_DONE;
        end else begin
          pc_next = emr_pkg::A_EMIT;
        end
      end
      emr_pkg::C_OUT: begin
        if (stat.out_free) pc_next = pc + 1'b1;
      end
      emr_pkg::C_OUT_JUMP: begin
        if (stat.out_free) pc_next = uw.target;
      end
      default: pc_next = emr_pkg::A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= emr_pkg::A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, out_step && !stat.out_free, $stable(pc))
  `ASSERT_IMP(a_pc_range, clk, rst, 1'b1, pc <= emr_pkg::A_MARK)
  `ASSERT_NEXT(a_leave_idle, clk, rst, pc == emr_pkg::A_IDLE && stat.accept, pc != emr_pkg::A_IDLE)

endmodule

[dv/tb_ellipse_midpoint_rasterizer.sv]
// self-checking testbench for ellipse_midpoint_rasterizer: streams start and advance items,
// predicts every point of the midpoint walk and checks each output item in order
// depends on emr_pkg and the rasterizer rtl
`timescale 1ns / 100ps

module tb_ellipse_midpoint_rasterizer;

  localparam int CB  = emr_pkg::COORD_BITS_DEF;
  localparam int RB  = emr_pkg::RADIUS_BITS_DEF;
  localparam int PW  = CB + 2;
  localparam int SDW = ((2 * CB + 2 * RB + 7) / 8) * 8;
  localparam int MDW = ((2 * PW + 7) / 8) * 8;
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;
  localparam int RANDOM_ITEMS = 250;
  localparam int CALM_ITEMS   = 40;
  localparam int LONG_STALL   = 250;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic          func;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic [RB-1:0] rx;
    logic [RB-1:0] ry;
    logic          drain;
  } cmd_t;

  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic                 pv;
    logic                 last;
    logic                 fin;
  } point_t;

  logic           clk;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [SDW-1:0] s_tdata = '0;
  logic           s_tuser = 1'b0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [MDW-1:0] m_tdata;
  logic [1:0]     m_tuser;
  logic           m_tlast;

  ellipse_midpoint_rasterizer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  cmd_t   cmd_q[$];
  point_t point_q[$];
  cmd_t   cur_cmd;
  point_t got;
  point_t want;

  // predictor state
  longint el_cx, el_cy, el_rx2, el_ry2, el_x, el_y, el_dx, el_dy, el_d;
  emr_pkg::phase_t el_phase;

  int errors = 0;
  int starts_sent = 0;
  int items_sent = 0;
  int points_seen = 0;
  int markers_seen = 0;
  int results_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit long_stall_done = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic trace_ellipse(input cmd_t c);
    longint rx, ry, xp, ym;
    point_t p;
    if (c.func == FUNC_ADVANCE && el_phase == emr_pkg::PH_DONE) begin
      p = '{px: '0, py: '0, pv: 1'b0, last: 1'b1, fin: 1'b1};
      point_q.push_back(p);
    end else begin
      if (c.func == FUNC_START) begin
        rx = c.rx;
        ry = c.ry;
        el_cx = c.cx;
        el_cy = c.cy;
        el_rx2 = rx * rx;
        el_ry2 = ry * ry;
        el_x = 0;
        el_y = ry;
        el_dx = 0;
        el_dy = 2 * ry * el_rx2;
        el_d = 2 * el_ry2 + el_rx2 - 2 * el_rx2 * ry;
        el_phase = emr_pkg::PH_R1;
        starts_sent++;
      end else if (el_phase == emr_pkg::PH_R1) begin
        el_x++;
        el_dx += 2 * el_ry2;
        if (el_d < 0) begin
          el_d += 2 * el_dx + 2 * el_ry2;
        end else begin
          el_y--;
          el_dy -= 2 * el_rx2;
          el_d += 2 * (el_dx - el_dy) + 2 * el_ry2;
        end
      end else begin
        el_y--;
        el_dy -= 2 * el_rx2;
        if (el_d > 0) begin
          el_d += 2 * el_rx2 - 2 * el_dy;
        end else begin
          el_x++;
          el_dx += 2 * el_ry2;
          el_d += 2 * el_rx2 + 2 * (el_dx - el_dy);
        end
      end
      // region change and end of walk are decided right after the item
      if (el_phase == emr_pkg::PH_R1 && !(el_dx < el_dy)) begin
        xp = el_x + 1;
        ym = el_y - 1;
        el_d = 2 * el_ry2 * xp * xp + el_rx2 * (el_y * el_y + ym * ym)
               - 2 * el_rx2 * el_ry2;
        el_phase = emr_pkg::PH_R2;
      end
      if (el_phase == emr_pkg::PH_R2 && el_y <= 0) el_phase = emr_pkg::PH_DONE;
      for (int k = 0; k < 4; k++) begin
        p.px  = PW'((k < 2) ? el_cx + el_x : el_cx - el_x);
        p.py  = PW'((k == 0 || k == 3) ? el_cy + el_y : el_cy - el_y);
        p.pv  = 1'b1;
        p.last = (k == 3);
        p.fin = (el_phase == emr_pkg::PH_DONE);
        point_q.push_back(p);
      end
    end
  endtask

  task automatic add_start(input int cx, input int cy, input int rx, input int ry);
    cmd_t c;
    c = '{func: FUNC_START, cx: CB'(cx), cy: CB'(cy), rx: RB'(rx), ry: RB'(ry), drain: 1'b0};
    cmd_q.push_back(c);
  endtask

  task automatic add_advance(input int n);
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      c.func = FUNC_ADVANCE;
      c.cx = CB'($urandom);
      c.cy = CB'($urandom);
      c.rx = RB'($urandom);
      c.ry = RB'($urandom);
      c.drain = 1'b0;
      cmd_q.push_back(c);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        trace_ellipse(cur_cmd);
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (cmd_q[0].drain && point_q.size() != 0) begin
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() > CALM_ITEMS && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(1, 6) - 1;
          s_tvalid <= 1'b0;
        end else begin
          cur_cmd = cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_cmd.func;
          s_tdata <= SDW'({cur_cmd.ry, cur_cmd.rx, cur_cmd.cy, cur_cmd.cx});
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.px = m_tdata[PW-1:0];
        got.py = m_tdata[2*PW-1:PW];
        got.pv = m_tuser[0];
        got.fin = m_tuser[1];
        got.last = m_tlast;
        results_seen++;
        if (got.pv) points_seen++;
        else markers_seen++;
        if (point_q.size() == 0) begin
          if (errors < 10)
            $display("ERROR: unexpected item x=%0d y=%0d pv=%b last=%b fin=%b",
                     got.px, got.py, got.pv, got.last, got.fin);
          errors++;
        end else begin
          want = point_q.pop_front();
          if (got.px !== want.px || got.py !== want.py || got.pv !== want.pv ||
              got.last !== want.last || got.fin !== want.fin) begin
            if (errors < 10)
              $display({"ERROR: item %0d exp x=%0d y=%0d pv=%b last=%b fin=%b, ",
                        "got x=%0d y=%0d pv=%b last=%b fin=%b"},
                       results_seen, want.px, want.py, want.pv, want.last, want.fin,
                       got.px, got.py, got.pv, got.last, got.fin);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!long_stall_done && results_seen >= 150) begin
        long_stall_done = 1;
        stall_left = LONG_STALL - 1;
        m_tready <= 1'b0;
      end else if (cmd_q.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items pending", cycle_count, point_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n_rand;
    int kind;
    int rx;
    int ry;
    bit drain_set;
    n_rand = 0;
    drain_set = 0;
    el_cx = 0; el_cy = 0; el_rx2 = 0; el_ry2 = 0; el_x = 0; el_y = 0;
    el_dx = 0; el_dy = 0; el_d = 0;
    el_phase = emr_pkg::PH_DONE;

    // directed: advance after reset, zero radii, extremes, axis walks, restart mid-walk
    add_advance(1);
    add_start(0, 0, 0, 0);
    add_advance(1);
    add_start(1023, 1023, 511, 511);
    add_advance(2);
    add_start(0, 1023, 0, 3);
    add_advance(4);
    add_start(512, 0, 3, 2);
    add_advance(3);
    add_start(5, 7, 2, 4);
    add_advance(2);
    add_start(0, 0, 511, 511);
    add_advance(1);

    while (n_rand < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (!drain_set && n_rand >= RANDOM_ITEMS / 2) begin
        drain_set = 1;
        add_start($urandom_range(0, 1023), $urandom_range(0, 1023), 4, 3);
        cmd_q[cmd_q.size() - 1].drain = 1'b1;
        add_advance(8);
        n_rand += 9;
      end else if (kind == 0) begin
        if ($urandom_range(0, 1))
          add_start($urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 511), $urandom_range(0, 511));
        else
          add_advance(1);
        n_rand++;
      end else if (kind == 1) begin
        rx = $urandom_range(0, 511);
        ry = $urandom_range(0, 511);
        add_start($urandom_range(0, 1023), $urandom_range(0, 1023), rx, ry);
        kind = $urandom_range(0, 6);
        add_advance(kind);
        n_rand += 1 + kind;
      end else begin
        rx = $urandom_range(0, 12);
        ry = $urandom_range(0, 12);
        add_start($urandom_range(0, 1023), $urandom_range(0, 1023), rx, ry);
        kind = $urandom_range(0, rx + ry + 2);
        add_advance(kind);
        n_rand += 1 + kind;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (cmd_q.size() != 0 || s_tvalid || point_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d items (%0d starts, rest advances) in %0d cycles",
             items_sent, starts_sent, cycle_count);
    $display("checked %0d points and %0d end markers, %0d mismatches",
             points_seen, markers_seen, errors);
    if (errors == 0 && point_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/emr_pkg.sv
src/emr_seq.sv
src/ellipse_midpoint_rasterizer.sv
dv/tb_ellipse_midpoint_rasterizer.sv
